// File: design/slip_reply_word_detector_macros.svh
// Assertion macros shared by the slip reply word detector checkers.
// Included by the checker file; depends on nothing else.
`ifndef SLIP_REPLY_WORD_DETECTOR_MACROS_SVH
`define SLIP_REPLY_WORD_DETECTOR_MACROS_SVH

// Next-cycle implication, masked while reset is high.
`define SRWD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("srwd check failed");

// Same-cycle implication, masked while reset is high.
`define SRWD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("srwd check failed");

// Next-cycle implication that is also checked during reset.
`define SRWD_ASSERT_RESET(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("srwd check failed");

`endif

// File: design/srwd_pkg.sv
// Shared types and byte codes for the slip reply word detector.
// No dependencies.
`timescale 1ns / 1ps

package srwd_pkg;

   // Reply framing codes
   localparam logic [7:0] CODE_CMD    = 8'h31;
   localparam logic [7:0] CODE_OK     = 8'h15;
   // SLIP codes
   localparam logic [7:0] SLIP_END    = 8'hC0;
   localparam logic [7:0] SLIP_ESC    = 8'hDB;
   localparam logic [7:0] SLIP_ESCEND = 8'hDC;
   localparam logic [7:0] SLIP_ESCESC = 8'hDD;

   // Bytes needed in the window for a full reply
   localparam logic [2:0] WIN_BYTES = 3'd6;

   // One classified beat passed from the front to the back
   typedef struct packed {
      logic       feed;   // byte goes to the matcher
      logic [7:0] data;   // decoded byte
      logic       last;   // end of receive run
   } srwd_entry_type;

   // Queue status seen by the back
   typedef struct packed {
      logic not_empty;
      logic full;
   } srwd_qstat_type;

endpackage

// File: design/srwd_if.sv
// Handshake channel interfaces for the slip reply word detector.
// Request bytes, result words and the mode register write channel.
`timescale 1ns / 1ps

interface srwd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       last_byte;
   modport source (output valid, rx_byte, last_byte, input ready);
   modport sink   (input valid, rx_byte, last_byte, output ready);
endinterface

interface srwd_rsp_if;
   logic        valid;
   logic        ready;
   logic        found;
   logic [31:0] reply_word;
   modport source (output valid, found, reply_word, input ready);
   modport sink   (input valid, found, reply_word, output ready);
endinterface

interface srwd_csr_if;
   logic valid;
   logic ready;
   logic slip_mode;
   modport source (output valid, slip_mode, input ready);
   modport sink   (input valid, slip_mode, output ready);
endinterface

// File: design/srwd_front.sv
// Front end: accepts request beats, holds the mode register, decodes SLIP
// framing and pushes one classified entry per beat. Uses srwd_pkg, srwd_if.
`timescale 1ns / 1ps

module srwd_front import srwd_pkg::*; #(
   parameter int DECODED_CAP = 32
) (
   input  logic            clock,
   input  logic            reset,
   srwd_req_if.sink        req_if,
   srwd_csr_if.sink        csr_if,
   input  srwd_qstat_type  q_stat,
   output logic            push,
   output srwd_entry_type  push_entry
);

   localparam int CNT_W = $clog2(DECODED_CAP + 1);
   localparam logic [CNT_W-1:0] CAP = CNT_W'(DECODED_CAP);

   logic             slip_mode_ff, slip_mode_in;
   logic             started_ff, started_in;
   logic             escape_ff, escape_in;
   logic             closed_ff, closed_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             accept;
   logic             feed;
   logic [7:0]       data;

   // Mode register: always writable
   assign csr_if.ready = 1'b1;
   assign slip_mode_in = (csr_if.valid) ? csr_if.slip_mode : slip_mode_ff;

   assign req_if.ready = !q_stat.full;
   assign accept       = req_if.valid && req_if.ready;

   // SLIP decode of the incoming beat
   always_comb begin
      started_in = started_ff;
      escape_in  = escape_ff;
      closed_in  = closed_ff;
      count_in   = count_ff;
      feed       = 1'b0;
      data       = req_if.rx_byte;
      if (!closed_ff) begin
         if (!slip_mode_ff) begin
            feed = 1'b1;
         end else if (req_if.rx_byte == SLIP_END) begin
            if (started_ff && (count_ff != '0)) begin
               closed_in = 1'b1;
            end else begin
               started_in = 1'b1;
            end
         end else if (started_ff) begin
            if (escape_ff) begin
               if (req_if.rx_byte == SLIP_ESCEND) begin
                  data = SLIP_END;
               end else if (req_if.rx_byte == SLIP_ESCESC) begin
                  data = SLIP_ESC;
               end
               escape_in = 1'b0;
               feed      = 1'b1;
            end else if (req_if.rx_byte == SLIP_ESC) begin
               escape_in = 1'b1;
            end else begin
               feed = 1'b1;
            end
            // keep only the first DECODED_CAP decoded bytes
            if (feed) begin
               if (count_ff < CAP) begin
                  count_in = count_ff + 1'b1;
               end else begin
                  feed = 1'b0;
               end
            end
         end
      end
      // run ends: clear frame state
      if (req_if.last_byte) begin
         started_in = 1'b0;
         escape_in  = 1'b0;
         closed_in  = 1'b0;
         count_in   = '0;
      end
   end

   assign push            = accept;
   assign push_entry.feed = feed;
   assign push_entry.data = data;
   assign push_entry.last = req_if.last_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         slip_mode_ff <= 1'b0;
         started_ff   <= 1'b0;
         escape_ff    <= 1'b0;
         closed_ff    <= 1'b0;
         count_ff     <= '0;
      end else begin
         slip_mode_ff <= slip_mode_in;
         if (accept) begin
            started_ff <= started_in;
            escape_ff  <= escape_in;
            closed_ff  <= closed_in;
            count_ff   <= count_in;
         end
      end
   end

endmodule

// File: design/srwd_queue.sv
// Two-entry queue between the front and back ends.
// Uses srwd_pkg for the entry and status types.
`timescale 1ns / 1ps

module srwd_queue import srwd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  srwd_entry_type push_entry,
   input  logic           pop,
   output srwd_qstat_type q_stat,
   output srwd_entry_type pop_entry
);

   srwd_entry_type mem_ff [2];
   logic [1:0]     count_ff, count_in;
   logic           wr_ptr_ff, rd_ptr_ff;
   logic           do_push, do_pop;

   assign q_stat.not_empty = (count_ff != 2'd0);
   assign q_stat.full      = (count_ff == 2'd2);
   assign do_push          = push && !q_stat.full;
   assign do_pop           = pop && q_stat.not_empty;
   assign pop_entry        = mem_ff[rd_ptr_ff];

   // occupancy
   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (do_push) wr_ptr_ff <= !wr_ptr_ff;
         if (do_pop)  rd_ptr_ff <= !rd_ptr_ff;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

// File: design/srwd_back.sv
// Back end: six-byte match window, result tracking and the output register.
// Uses srwd_pkg and srwd_rsp_if.
`timescale 1ns / 1ps

module srwd_back import srwd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  srwd_qstat_type q_stat,
   input  srwd_entry_type pop_entry,
   output logic           pop,
   srwd_rsp_if.source     rsp_if
);

   logic [47:0] window_ff, window_in;
   logic [2:0]  fill_ff, fill_in;
   logic        given_ff, given_in;
   logic        rsp_valid_ff;
   logic        found_ff, found_in;
   logic [31:0] word_ff, word_in;
   logic        produce;

   // take an entry whenever the output slot is free or draining
   assign pop = q_stat.not_empty && (!rsp_valid_ff || rsp_if.ready);

   always_comb begin
      window_in = window_ff;
      fill_in   = fill_ff;
      given_in  = given_ff;
      produce   = 1'b0;
      found_in  = 1'b0;
      word_in   = '0;
      if (!given_ff && pop_entry.feed) begin
         window_in = {window_ff[39:0], pop_entry.data};
         if (fill_ff < WIN_BYTES) fill_in = fill_ff + 3'd1;
         if ((fill_in == WIN_BYTES) && (window_in[47:40] == CODE_CMD) &&
             (window_in[7:0] == CODE_OK)) begin
            produce  = 1'b1;
            found_in = 1'b1;
            word_in  = {window_in[15:8], window_in[23:16],
                        window_in[31:24], window_in[39:32]};
            given_in = 1'b1;
         end
      end
      // run ended without a match
      if (!produce && pop_entry.last && !given_ff) begin
         produce = 1'b1;
      end
      if (pop_entry.last) begin
         window_in = '0;
         fill_in   = '0;
         given_in  = 1'b0;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.found      = found_ff;
   assign rsp_if.reply_word = word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= '0;
         fill_ff      <= '0;
         given_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            window_ff <= window_in;
            fill_ff   <= fill_in;
            given_ff  <= given_in;
         end
         if (pop && produce) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (pop && produce) begin
         found_ff <= found_in;
         word_ff  <= word_in;
      end
   end

endmodule

// File: design/slip_reply_word_detector.sv
// A taken beat is written into the queue, then its result into the output
// register. One byte per cycle while the output is not stalled; the two-entry
// queue and output register let input and output stall independently.
// Reset (synchronous, active high) clears the mode register to raw, the frame
// and match state, the queue and the output valid.
`timescale 1ns / 1ps

module slip_reply_word_detector import srwd_pkg::*; #(
   parameter int DECODED_CAP = 32
) (
   input  logic        clock,
   input  logic        reset,
   srwd_req_if.sink    req_if,
   srwd_rsp_if.source  rsp_if,
   srwd_csr_if.sink    csr_if
);

   srwd_qstat_type q_stat;
   srwd_entry_type push_entry, pop_entry;
   logic           push, pop;

   // decode and classify
   srwd_front #(.DECODED_CAP(DECODED_CAP)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .csr_if     (csr_if),
      .q_stat     (q_stat),
      .push       (push),
      .push_entry (push_entry)
   );

   srwd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .q_stat     (q_stat),
      .pop_entry  (pop_entry)
   );

   // match and respond
   srwd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_stat    (q_stat),
      .pop_entry (pop_entry),
      .pop       (pop),
      .rsp_if    (rsp_if)
   );

endmodule

// File: design/srwd_checker.sv
// Port-level checks for the slip reply word detector, bound to the top.
// Uses slip_reply_word_detector_macros.svh.
`timescale 1ns / 1ps
`include "slip_reply_word_detector_macros.svh"

module srwd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_found,
   input logic [31:0] rsp_word
);

   // a waiting result beat holds
   `SRWD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_found) && $stable(rsp_word))
   // a not-found result carries a zero word
   `SRWD_ASSERT_NOW(a_notfound_zero, clock, reset, rsp_valid && !rsp_found, rsp_word == 32'd0)
   // reset drops any pending result
   `SRWD_ASSERT_RESET(a_reset_rsp, clock, reset, !rsp_valid)
   // queue is empty after reset, so input is open
   `SRWD_ASSERT_RESET(a_reset_ready, clock, reset, req_ready)

endmodule

bind slip_reply_word_detector srwd_checker u_srwd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_found (rsp_if.found),
   .rsp_word  (rsp_if.reply_word)
);

// File: verif/testbench.sv
// Self-checking bench for the SLIP reply word detector: drives byte runs in raw and SLIP
// mode, predicts each found / not-found result and checks them in order.
// Depends on srwd_pkg, the srwd channel interfaces and slip_reply_word_detector.
`timescale 1ns / 1ps

module testbench import srwd_pkg::*; ();

   localparam int DECODED_CAP = 32;
   localparam int DRAIN_CYCLES = 6;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } rx_beat_type;

   typedef struct packed {
      logic        found;
      logic [31:0] word;
   } word_reply_type;

   typedef enum int {RX_OPEN, RX_COIN, RX_THREE_OF_FOUR, RX_TRICKLE} stall_kind_type;

   logic clock = 1'b0;
   logic reset;

   srwd_req_if req_ch ();
   srwd_rsp_if rsp_ch ();
   srwd_csr_if csr_ch ();

   slip_reply_word_detector #(.DECODED_CAP(DECODED_CAP)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   always #1 clock = ~clock;

   rx_beat_type    rx_pending[$];
   word_reply_type expected_replies[$];
   int             item_total = 0;
   int             mismatches = 0;

   // Detector copy: mode register plus per-run state
   logic        mode_slip   = 1'b0;
   logic [47:0] det_window  = '0;
   logic [2:0]  det_fill    = '0;
   logic [5:0]  det_count   = '0;
   logic        det_started = 1'b0;
   logic        det_esc     = 1'b0;
   logic        det_closed  = 1'b0;
   logic        det_given   = 1'b0;

   // Sender burst / gap and receiver stall bookkeeping
   int             burst_left = 8;
   int             gap_left   = 0;
   int             cycle_no   = 0;
   stall_kind_type stall_kind = RX_OPEN;

   task automatic flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
      $display("%0t ns: %s: expected %h, got %h", $time, what, want, got);
      mismatches++;
   endtask

   // Advance the detector by one accepted beat and queue any result it gives
   function automatic void advance_detector(logic [7:0] rx, logic last);
      logic [7:0]     b;
      logic           feed;
      logic           hit;
      word_reply_type r;
      b = rx;
      feed = 1'b0;
      hit = 1'b0;
      if (!det_given && !det_closed) begin
         if (!mode_slip) begin
            feed = 1'b1;
         end else if (b == SLIP_END) begin
            // delimiter: close after content, else (re)open
            if (det_started && det_count != 0)
               det_closed = 1'b1;
            else
               det_started = 1'b1;
         end else if (det_started) begin
            if (det_esc) begin
               if (b == SLIP_ESCEND)
                  b = SLIP_END;
               else if (b == SLIP_ESCESC)
                  b = SLIP_ESC;
               det_esc = 1'b0;
               feed = 1'b1;
            end else if (b == SLIP_ESC) begin
               det_esc = 1'b1;
            end else begin
               feed = 1'b1;
            end
            // bytes past the cap never reach the window
            if (feed) begin
               if (det_count < DECODED_CAP)
                  det_count++;
               else
                  feed = 1'b0;
            end
         end
         if (feed) begin
            det_window = {det_window[39:0], b};
            if (det_fill < WIN_BYTES)
               det_fill++;
            if (det_fill == WIN_BYTES && det_window[47:40] == CODE_CMD &&
                det_window[7:0] == CODE_OK) begin
               hit = 1'b1;
               det_given = 1'b1;
               r.found = 1'b1;
               r.word = {det_window[15:8], det_window[23:16],
                         det_window[31:24], det_window[39:32]};
               expected_replies.push_back(r);
            end
         end
      end
      if (!hit && last && !det_given) begin
         r.found = 1'b0;
         r.word = '0;
         expected_replies.push_back(r);
      end
      if (last) begin
         det_window = '0;
         det_fill = '0;
         det_count = '0;
         det_started = 1'b0;
         det_esc = 1'b0;
         det_closed = 1'b0;
         det_given = 1'b0;
      end
   endfunction

   // Sender: bursts of beats with random gaps, fed from rx_pending
   always @(posedge clock) begin : drive_rx
      rx_beat_type nxt;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            advance_detector(req_ch.rx_byte, req_ch.last_byte);
         if (!req_ch.valid || req_ch.ready) begin
            if (req_ch.valid) begin
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
            if (gap_left > 0) begin
               gap_left--;
               req_ch.valid <= 1'b0;
            end else if (rx_pending.size() != 0) begin
               nxt = rx_pending.pop_front();
               req_ch.rx_byte <= nxt.data;
               req_ch.last_byte <= nxt.last;
               req_ch.valid <= 1'b1;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: checks each result beat and stalls on a changing pattern
   always @(posedge clock) begin : watch_rsp
      word_reply_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_replies.size() == 0) begin
               flag_mismatch("result with nothing expected", '0, rsp_ch.reply_word);
            end else begin
               want = expected_replies.pop_front();
               if (rsp_ch.found !== want.found)
                  flag_mismatch("found", 32'(want.found), 32'(rsp_ch.found));
               if (rsp_ch.reply_word !== want.word)
                  flag_mismatch("reply_word", want.word, rsp_ch.reply_word);
            end
         end
         cycle_no++;
         if (cycle_no % 128 == 0)
            stall_kind = stall_kind_type'($urandom_range(0, 3));
         case (stall_kind)
            RX_OPEN:          rsp_ch.ready <= 1'b1;
            RX_COIN:          rsp_ch.ready <= 1'($urandom_range(0, 1));
            RX_THREE_OF_FOUR: rsp_ch.ready <= (cycle_no % 4 != 0);
            default:          rsp_ch.ready <= (cycle_no % 8 == 0);
         endcase
      end
   end

   function automatic logic [7:0] any_byte();
      // lean toward the codes the detector reacts to
      case ($urandom_range(0, 11))
         0:       return SLIP_END;
         1:       return SLIP_ESC;
         2:       return SLIP_ESCEND;
         3:       return SLIP_ESCESC;
         4:       return CODE_CMD;
         5:       return CODE_OK;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic queue_run(ref logic [7:0] bytes[$], input bit end_run);
      rx_beat_type bt;
      foreach (bytes[i]) begin
         bt.data = bytes[i];
         bt.last = end_run && (i == bytes.size() - 1);
         rx_pending.push_back(bt);
         item_total++;
      end
   endtask

   // Decoded content: filler, usually a reply (sometimes broken), a short tail
   task automatic make_content(ref logic [7:0] plain[$], input int long_fill);
      int n;
      int spoil;
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(20, long_fill) : $urandom_range(0, 6);
      repeat (n) plain.push_back(any_byte());
      if ($urandom_range(0, 4) != 0) begin
         spoil = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 5) : -1;
         plain.push_back(spoil == 0 ? any_byte() : CODE_CMD);
         for (int k = 1; k < 5; k++)
            plain.push_back(8'($urandom_range(0, 255)));
         plain.push_back(spoil == 5 ? any_byte() : CODE_OK);
         if (spoil > 0 && spoil < 5)
            plain.delete(plain.size() - 1 - $urandom_range(0, 3));
      end
      repeat ($urandom_range(0, 3)) plain.push_back(any_byte());
   endtask

   task automatic add_raw_run(bit end_run);
      logic [7:0] plain[$];
      make_content(plain, 90);
      if (plain.size() == 0)
         plain.push_back(any_byte());
      queue_run(plain, end_run);
   endtask

   task automatic add_slip_run(bit end_run);
      logic [7:0] plain[$];
      logic [7:0] wire_bytes[$];
      if ($urandom_range(0, 7) == 0) begin
         // plain noise
         repeat ($urandom_range(1, 12)) wire_bytes.push_back(any_byte());
      end else begin
         repeat ($urandom_range(0, 2)) wire_bytes.push_back(8'($urandom_range(0, 255)));
         repeat ($urandom_range(1, 2)) wire_bytes.push_back(SLIP_END);
         make_content(plain, 40);
         foreach (plain[i]) begin
            if ($urandom_range(0, 39) == 0) begin
               wire_bytes.push_back(SLIP_ESC);
               wire_bytes.push_back(SLIP_END);
            end
            if (plain[i] == SLIP_END) begin
               wire_bytes.push_back(SLIP_ESC);
               wire_bytes.push_back(SLIP_ESCEND);
            end else if (plain[i] == SLIP_ESC) begin
               wire_bytes.push_back(SLIP_ESC);
               wire_bytes.push_back(SLIP_ESCESC);
            end else if ($urandom_range(0, 7) == 0 && plain[i] != SLIP_ESCEND &&
                         plain[i] != SLIP_ESCESC) begin
               // needless escape still decodes to the byte itself
               wire_bytes.push_back(SLIP_ESC);
               wire_bytes.push_back(plain[i]);
            end else begin
               wire_bytes.push_back(plain[i]);
            end
         end
         if ($urandom_range(0, 3) != 0)
            wire_bytes.push_back(SLIP_END);
         repeat ($urandom_range(0, 2)) wire_bytes.push_back(any_byte());
      end
      queue_run(wire_bytes, end_run);
   endtask

   task automatic drain();
      do @(negedge clock);
      while (rx_pending.size() != 0 || req_ch.valid || expected_replies.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_mode(logic m);
      @(posedge clock);
      csr_ch.slip_mode <= m;
      csr_ch.valid <= 1'b1;
      do @(posedge clock);
      while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      mode_slip = m;
   endtask

   initial begin : stimulus
      logic [7:0] run_a[$];
      logic [7:0] run_b[$];
      logic [7:0] run_c[$];
      logic [7:0] run_d[$];
      logic       slip;
      int         runs;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.rx_byte = '0;
      req_ch.last_byte = 1'b0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.slip_mode = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Raw: match on the last byte with extreme data, then a one-byte miss
      run_a = '{CODE_CMD, 8'hFF, 8'h00, 8'h80, 8'h7F, CODE_OK};
      run_b = '{8'h00};
      write_mode(1'b0);
      queue_run(run_a, 1'b1);
      queue_run(run_b, 1'b1);
      drain();

      // SLIP: junk before the opener, repeated opener, both escapes, a needless
      // escape, bytes after the match; then escape before a delimiter and a close
      run_c = '{8'hAA, SLIP_END, SLIP_END, CODE_CMD, SLIP_ESC, SLIP_ESCEND,
                SLIP_ESC, SLIP_ESCESC, SLIP_ESC, 8'h41, 8'h7E, CODE_OK, 8'h22};
      run_d = '{SLIP_END, SLIP_ESC, SLIP_END, SLIP_ESCEND, 8'h05, SLIP_END, CODE_CMD};
      write_mode(1'b1);
      queue_run(run_c, 1'b1);
      queue_run(run_d, 1'b1);
      drain();

      // Random phases; a phase may stop mid-run so the mode flips inside a run
      while (item_total < 2000) begin
         slip = ($urandom_range(0, 3) != 0);
         write_mode(slip);
         runs = $urandom_range(1, 8);
         for (int i = 0; i < runs; i++) begin
            if (slip)
               add_slip_run(!(i == runs - 1 && $urandom_range(0, 3) == 0));
            else
               add_raw_run(!(i == runs - 1 && $urandom_range(0, 3) == 0));
         end
         drain();
      end

      if (mismatches == 0)
         $display("slip_reply_word_detector: match");
      else
         $display("slip_reply_word_detector: mismatch");
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("slip_reply_word_detector: mismatch");
      $finish;
   end

endmodule
